// ----- hw/rtl/control_loop_health_guard_macros.svh -----
// Assertion macros shared by the control loop health guard RTL.
`ifndef CONTROL_LOOP_HEALTH_GUARD_MACROS_SVH
`define CONTROL_LOOP_HEALTH_GUARD_MACROS_SVH

// Same-cycle implication, sampled on clock and disabled while reset is high.
`define CLHG_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, sampled on clock and disabled while reset is high.
`define CLHG_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- hw/rtl/clhg_pkg.sv -----
// Types, codes and helpers shared by the control loop health guard.
package clhg_pkg;

   // Guard states as reported in the result item.
   typedef enum logic [1:0] {
      MODE_MONITOR = 2'd0,
      MODE_SUSPECT = 2'd1,
      MODE_LATCHED = 2'd2,
      MODE_RECOVER = 2'd3
   } clhg_mode_type;

   localparam int unsigned CountWidth  = 16;
   localparam int unsigned ReasonWidth = 9;
   localparam int unsigned CodeWidth   = 8;
   localparam int unsigned CsrIdxWidth = 8;

   // Reason codes held in the stored reason.
   localparam logic [ReasonWidth-1:0] RSN_NONE        = 9'd0;
   localparam logic [CodeWidth-1:0]   CODE_NONE       = 8'd0;
   localparam logic [CodeWidth-1:0]   CODE_DEADLINE   = 8'd1;
   localparam logic [ReasonWidth-1:0] RSN_WARMING     = 9'd256;
   localparam logic [ReasonWidth-1:0] RSN_HEALTHY     = 9'd257;
   localparam logic [ReasonWidth-1:0] RSN_UNHEALTHY   = 9'd258;
   localparam logic [ReasonWidth-1:0] RSN_RESUME_FAIL = 9'd259;

   // Configuration register indexes and reset values.
   localparam logic [CsrIdxWidth-1:0] CSR_UNHEALTHY_CONFIRM = 8'd0;
   localparam logic [CsrIdxWidth-1:0] CSR_RECOVERY_CONFIRM  = 8'd1;
   localparam logic [CountWidth-1:0]  UNHEALTHY_CONFIRM_RST = 16'd3;
   localparam logic [CountWidth-1:0]  RECOVERY_CONFIRM_RST  = 16'd10;

   // One input item.
   typedef struct packed {
      logic                 cmd;
      logic                 ready_req;
      logic                 healthy;
      logic [CodeWidth-1:0] reason_code;
      logic                 resume_ok;
   } clhg_item_type;

   // Guard state carried from item to item.
   typedef struct packed {
      clhg_mode_type          mode;
      logic [CountWidth-1:0]  unhealthy_run;
      logic [CountWidth-1:0]  recovery_run;
      logic [ReasonWidth-1:0] last_reason;
   } clhg_state_type;

   // One result item.
   typedef struct packed {
      logic [1:0]             guard_state;
      logic                   stop_pulse;
      logic                   hold_active;
      logic                   resume_allowed;
      logic                   resume_done;
      logic [ReasonWidth-1:0] reason_out;
   } clhg_result_type;

   // Run counter increment that sticks at its maximum.
   function automatic logic [CountWidth-1:0] sat_inc(input logic [CountWidth-1:0] v);
      sat_inc = (v == {CountWidth{1'b1}}) ? v : v + {{(CountWidth-1){1'b0}}, 1'b1};
   endfunction

   // A passed code, or the given fallback when no code was passed.
   function automatic logic [ReasonWidth-1:0] pick_reason(
      input logic [CodeWidth-1:0]   code,
      input logic [ReasonWidth-1:0] fallback
   );
      pick_reason = (code == CODE_NONE) ? fallback : {1'b0, code};
   endfunction

endpackage

// ----- hw/rtl/control_loop_health_guard.sv -----
// Top level of the control loop health guard.
// A result item is registered and appears in the cycle after its input item is accepted.
// Throughput: one item per cycle; the guard state and the result register
// update together, and a new item is taken whenever the result register is
// empty or being taken. Synchronous reset returns the guard to monitoring,
// clears both runs and the reason, and restores the confirm counts to 3 and 10.
`include "control_loop_health_guard_macros.svh"

module control_loop_health_guard (
   input  logic        clock,
   input  logic        reset,
   // Input items.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,  // ready_req, healthy, reason_code[7:0], resume_ok, zero pad
   input  logic        req_tuser,  // cmd
   // Result items.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,  // guard_state[1:0], stop_pulse, hold_active,
                                   // resume_allowed, resume_done, reason_out[8:0], zero pad
   // Configuration writes.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [clhg_pkg::CsrIdxWidth-1:0]  csr_index,
   input  logic [clhg_pkg::CountWidth-1:0]   csr_data
);
   import clhg_pkg::*;

   clhg_state_type        state_ff;
   clhg_state_type        state_in;
   clhg_item_type         item;
   clhg_result_type       result;
   logic [CountWidth-1:0] unh_confirm_ff;
   logic [CountWidth-1:0] rec_confirm_ff;
   logic                  rsp_valid_ff;
   logic [15:0]           rsp_data_ff;
   logic                  req_accept;

   // Unpack the input item.
   assign item.cmd         = req_tuser;
   assign item.ready_req   = req_tdata[0];
   assign item.healthy     = req_tdata[1];
   assign item.reason_code = req_tdata[9:2];
   assign item.resume_ok   = req_tdata[10];

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;

   clhg_step u_step (
      .cur_state         (state_ff),
      .item              (item),
      .unhealthy_confirm (unh_confirm_ff),
      .recovery_confirm  (rec_confirm_ff),
      .nxt_state         (state_in),
      .result            (result)
   );

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         unh_confirm_ff <= UNHEALTHY_CONFIRM_RST;
         rec_confirm_ff <= RECOVERY_CONFIRM_RST;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_UNHEALTHY_CONFIRM: unh_confirm_ff <= csr_data;
            CSR_RECOVERY_CONFIRM:  rec_confirm_ff <= csr_data;
            default: ;
         endcase
      end
   end

   // Guard state advances on every accepted item.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.mode          <= MODE_MONITOR;
         state_ff.unhealthy_run <= '0;
         state_ff.recovery_run  <= '0;
         state_ff.last_reason   <= RSN_NONE;
      end else if (req_accept) begin
         state_ff <= state_in;
      end
   end

   // Result register and its valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_data_ff <= {1'b0, result.reason_out, result.resume_done, result.resume_allowed,
                         result.hold_active, result.stop_pulse, result.guard_state};
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Checks on the guard's own bookkeeping.
   `CLHG_ASSERT_NXT(a_accept_gives_result, req_accept, rsp_tvalid, "accepted item gave no result")
   `CLHG_ASSERT_IMP(a_stop_only_latched, rsp_tvalid && rsp_tdata[2], rsp_tdata[1:0] == MODE_LATCHED, "stop pulse outside latched")
   `CLHG_ASSERT_IMP(a_unh_run_suspect, state_ff.unhealthy_run != '0, state_ff.mode == MODE_SUSPECT, "unhealthy run outside suspect")
   `CLHG_ASSERT_IMP(a_done_monitor, rsp_tvalid && rsp_tdata[5], rsp_tdata[1:0] == MODE_MONITOR && rsp_tdata[14:6] == RSN_HEALTHY, "resume_done without healthy monitoring")

endmodule

// ----- hw/rtl/clhg_step.sv -----
// Next-state and result logic of the health guard for one item.
module clhg_step (
   input  clhg_pkg::clhg_state_type          cur_state,
   input  clhg_pkg::clhg_item_type           item,
   input  logic [clhg_pkg::CountWidth-1:0]   unhealthy_confirm,
   input  logic [clhg_pkg::CountWidth-1:0]   recovery_confirm,
   output clhg_pkg::clhg_state_type          nxt_state,
   output clhg_pkg::clhg_result_type         result
);
   import clhg_pkg::*;

   logic [CountWidth-1:0]  unh_inc;
   logic [CountWidth-1:0]  rec_inc;
   logic [ReasonWidth-1:0] unh_reason;
   logic                   stop_pulse;
   logic                   resume_done;

   assign unh_inc    = sat_inc(cur_state.unhealthy_run);
   assign rec_inc    = sat_inc(cur_state.recovery_run);
   assign unh_reason = pick_reason(item.reason_code, RSN_UNHEALTHY);

   // Decide the new state for this item.
   always_comb begin
      nxt_state    = cur_state;
      stop_pulse   = 1'b0;
      resume_done  = 1'b0;
      if (item.cmd) begin
         // Resume completion only acts while recovered.
         if (cur_state.mode == MODE_RECOVER) begin
            nxt_state.unhealthy_run = '0;
            nxt_state.recovery_run  = '0;
            if (item.resume_ok) begin
               nxt_state.mode        = MODE_MONITOR;
               nxt_state.last_reason = RSN_HEALTHY;
               resume_done           = 1'b1;
            end else begin
               nxt_state.mode        = MODE_LATCHED;
               nxt_state.last_reason = RSN_RESUME_FAIL;
            end
         end
      end else if (!item.ready_req) begin
         // Loop not warmed up: clear runs, record the reason, and leave suspect or recover.
         nxt_state.unhealthy_run = '0;
         nxt_state.recovery_run  = '0;
         nxt_state.last_reason   = pick_reason(item.reason_code, RSN_WARMING);
         if (cur_state.mode == MODE_SUSPECT) begin
            nxt_state.mode = MODE_MONITOR;
         end else if (cur_state.mode == MODE_RECOVER) begin
            nxt_state.mode = MODE_LATCHED;
         end
      end else if (item.healthy) begin
         // Healthy sample: return to monitoring from suspect, count toward recovery while latched.
         nxt_state.unhealthy_run = '0;
         if (cur_state.mode == MODE_MONITOR || cur_state.mode == MODE_SUSPECT) begin
            nxt_state.mode         = MODE_MONITOR;
            nxt_state.recovery_run = '0;
            nxt_state.last_reason  = pick_reason(item.reason_code, RSN_HEALTHY);
         end else if (cur_state.mode == MODE_LATCHED) begin
            nxt_state.recovery_run = rec_inc;
            if (rec_inc >= recovery_confirm) begin
               nxt_state.mode = MODE_RECOVER;
            end
         end
      end else begin
         // Unhealthy sample: relatch, latch on confirm or a deadline code, or become suspect.
         nxt_state.recovery_run = '0;
         nxt_state.last_reason  = unh_reason;
         if (cur_state.mode == MODE_LATCHED || cur_state.mode == MODE_RECOVER) begin
            nxt_state.mode          = MODE_LATCHED;
            nxt_state.unhealthy_run = '0;
         end else if (item.reason_code == CODE_DEADLINE || unh_inc >= unhealthy_confirm) begin
            nxt_state.mode          = MODE_LATCHED;
            nxt_state.unhealthy_run = '0;
            stop_pulse              = 1'b1;
         end else begin
            nxt_state.mode          = MODE_SUSPECT;
            nxt_state.unhealthy_run = unh_inc;
         end
      end
   end

   // The result reports the decision from the new state.
   always_comb begin
      result.guard_state    = nxt_state.mode;
      result.stop_pulse     = stop_pulse;
      result.hold_active    = (nxt_state.mode == MODE_LATCHED) ||
                              (nxt_state.mode == MODE_RECOVER);
      result.resume_allowed = (nxt_state.mode == MODE_RECOVER);
      result.resume_done    = resume_done;
      result.reason_out     = nxt_state.last_reason;
   end

endmodule
